// ===== rtl/core/lswc_pkg.sv =====
// ============================================================================
// lswc_pkg: shared types and constants for the line segment window clipper
// Coordinate widths, fraction and stage structs, register indexes.
// ============================================================================
package lswc_pkg;

    localparam int C          = 12;               // coordinate width
    localparam int DW         = C + 1;            // deltas, boundary distances
    localparam int PW         = 2 * DW;           // cross products
    localparam int NUM_W      = 2 * DW + 1;       // interpolation numerators
    localparam int DIV_STAGES = (C + 1) / 2;      // two quotient bits per stage
    localparam int QB         = 2 * DIV_STAGES;
    localparam int IN_W       = 4 * C;
    localparam int TDATA_W    = ((IN_W + 7) / 8) * 8;

    localparam logic [1:0] REG_WIN_X_MIN = 2'd0;
    localparam logic [1:0] REG_WIN_Y_MIN = 2'd1;
    localparam logic [1:0] REG_WIN_X_MAX = 2'd2;
    localparam logic [1:0] REG_WIN_Y_MAX = 2'd3;

    localparam logic signed [C-1:0] WIN_MIN_RESET = C'(200);
    localparam logic signed [C-1:0] WIN_MAX_RESET = C'(400);

    typedef struct packed {
        logic signed [C-1:0] x_min;
        logic signed [C-1:0] y_min;
        logic signed [C-1:0] x_max;
        logic signed [C-1:0] y_max;
    } win_t;

    // t = n / d with d > 0
    typedef struct packed {
        logic signed [DW-1:0] n;
        logic [C-1:0]         d;
    } frac_t;

    typedef struct packed {
        logic                 valid;
        logic                 reject;
        logic signed [C-1:0]  x1;
        logic signed [C-1:0]  y1;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        frac_t                t1x;
        frac_t                t2x;
        frac_t                t1y;
        frac_t                t2y;
    } cand_t;

    typedef struct packed {
        logic                    valid;
        logic                    visible;
        logic signed [NUM_W-1:0] sx;
        logic signed [NUM_W-1:0] sy;
        logic signed [NUM_W-1:0] ex;
        logic signed [NUM_W-1:0] ey;
        logic [C-1:0]            d1;
        logic [C-1:0]            d2;
    } numer_t;

    function automatic logic signed [DW-1:0] ext(input logic signed [C-1:0] v);
        return {v[C-1], v};
    endfunction

    function automatic logic signed [DW-1:0] den_s(input logic [C-1:0] d);
        return {1'b0, d};
    endfunction

endpackage

// ===== rtl/core/lswc_setup.sv =====
// ============================================================================
// lswc_setup: deltas, boundary distances and per-axis candidate parameters
// Two register stages; each axis yields one entering and one leaving fraction.
// ============================================================================
module lswc_setup import lswc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [C-1:0] x1,
    input  logic signed [C-1:0] y1,
    input  logic signed [C-1:0] x2,
    input  logic signed [C-1:0] y2,
    input  win_t                win,
    output cand_t               cand
);

    typedef struct packed {
        logic  rej;
        frac_t t1;
        frac_t t2;
    } axis_t;

    function automatic axis_t axis_cand(input logic signed [DW-1:0] d,
                                        input logic signed [DW-1:0] q_lo,
                                        input logic signed [DW-1:0] q_hi);
        axis_t a;
        a.rej  = 1'b0;
        a.t1.n = '0;
        a.t1.d = C'(1);
        a.t2.n = DW'(1);
        a.t2.d = C'(1);
        if (d == '0) begin
            a.rej = q_lo[DW-1] | q_hi[DW-1];
        end else if (!d[DW-1]) begin
            a.t1.n = -q_lo;
            a.t1.d = d[C-1:0];
            a.t2.n = q_hi;
            a.t2.d = d[C-1:0];
        end else begin
            a.t1.n = -q_hi;
            a.t1.d = C'(-d);
            a.t2.n = q_lo;
            a.t2.d = C'(-d);
        end
        // clamp to [0, 1]
        if (a.t1.n <= 0) begin
            a.t1.n = '0;
            a.t1.d = C'(1);
        end
        if (a.t2.n >= den_s(a.t2.d)) begin
            a.t2.n = DW'(1);
            a.t2.d = C'(1);
        end
        return a;
    endfunction

    logic                 va_reg;
    logic signed [C-1:0]  x1_reg, y1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [DW-1:0] qxl_reg, qxh_reg, qyl_reg, qyh_reg;
    cand_t                cand_reg, cand_next;
    axis_t                ax, ay;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg         <= 1'b0;
            cand_reg.valid <= 1'b0;
        end else if (en) begin
            va_reg   <= in_valid;
            x1_reg   <= x1;
            y1_reg   <= y1;
            dx_reg   <= ext(x2) - ext(x1);
            dy_reg   <= ext(y2) - ext(y1);
            qxl_reg  <= ext(x1) - ext(win.x_min);
            qxh_reg  <= ext(win.x_max) - ext(x1);
            qyl_reg  <= ext(y1) - ext(win.y_min);
            qyh_reg  <= ext(win.y_max) - ext(y1);
            cand_reg <= cand_next;
        end
    end

    always_comb begin
        ax               = axis_cand(dx_reg, qxl_reg, qxh_reg);
        ay               = axis_cand(dy_reg, qyl_reg, qyh_reg);
        cand_next.valid  = va_reg;
        cand_next.reject = ax.rej | ay.rej;
        cand_next.x1     = x1_reg;
        cand_next.y1     = y1_reg;
        cand_next.dx     = dx_reg;
        cand_next.dy     = dy_reg;
        cand_next.t1x    = ax.t1;
        cand_next.t2x    = ax.t2;
        cand_next.t1y    = ay.t1;
        cand_next.t2y    = ay.t2;
    end

    assign cand = cand_reg;

endmodule

// ===== rtl/core/lswc_select.sv =====
// ============================================================================
// lswc_select: picks t1/t2 by cross multiplication, final reject test and
// interpolation numerators. Two register stages.
// ============================================================================
module lswc_select import lswc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  cand_t  cand,
    output numer_t numer
);

    logic                 vc_reg, rej_reg;
    logic signed [C-1:0]  x1_reg, y1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    frac_t                t1_reg, t2_reg;
    logic signed [PW-1:0] a1, b1, a2, b2, c1, c2;
    numer_t               numer_reg;

    always_comb begin
        a1 = PW'(cand.t1y.n) * PW'(den_s(cand.t1x.d));
        b1 = PW'(cand.t1x.n) * PW'(den_s(cand.t1y.d));
        a2 = PW'(cand.t2y.n) * PW'(den_s(cand.t2x.d));
        b2 = PW'(cand.t2x.n) * PW'(den_s(cand.t2y.d));
        c1 = PW'(t1_reg.n) * PW'(den_s(t2_reg.d));
        c2 = PW'(t2_reg.n) * PW'(den_s(t1_reg.d));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg          <= 1'b0;
            numer_reg.valid <= 1'b0;
        end else if (en) begin
            vc_reg  <= cand.valid;
            rej_reg <= cand.reject;
            x1_reg  <= cand.x1;
            y1_reg  <= cand.y1;
            dx_reg  <= cand.dx;
            dy_reg  <= cand.dy;
            t1_reg  <= (a1 > b1) ? cand.t1y : cand.t1x;
            t2_reg  <= (a2 < b2) ? cand.t2y : cand.t2x;

            numer_reg.valid   <= vc_reg;
            numer_reg.visible <= !rej_reg && !(c1 > c2);
            numer_reg.sx <= NUM_W'(x1_reg) * NUM_W'(den_s(t1_reg.d))
                          + NUM_W'(dx_reg) * NUM_W'(t1_reg.n);
            numer_reg.sy <= NUM_W'(y1_reg) * NUM_W'(den_s(t1_reg.d))
                          + NUM_W'(dy_reg) * NUM_W'(t1_reg.n);
            numer_reg.ex <= NUM_W'(x1_reg) * NUM_W'(den_s(t2_reg.d))
                          + NUM_W'(dx_reg) * NUM_W'(t2_reg.n);
            numer_reg.ey <= NUM_W'(y1_reg) * NUM_W'(den_s(t2_reg.d))
                          + NUM_W'(dy_reg) * NUM_W'(t2_reg.n);
            numer_reg.d1 <= t1_reg.d;
            numer_reg.d2 <= t2_reg.d;
        end
    end

    assign numer = numer_reg;

endmodule

// ===== rtl/core/lswc_div.sv =====
// ============================================================================
// lswc_div: pipelined restoring divider, signed numerator by positive
// denominator, quotient truncated toward zero. Two quotient bits per stage.
// ============================================================================
module lswc_div import lswc_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [C-1:0]            den,
    output logic signed [C-1:0]     quo
);

    logic [NUM_W-1:0] rem_reg [DIV_STAGES];
    logic [NUM_W-1:0] rem_next[DIV_STAGES];
    logic [QB-1:0]    quo_reg [DIV_STAGES];
    logic [QB-1:0]    quo_next[DIV_STAGES];
    logic [C-1:0]     den_reg [DIV_STAGES];
    logic [C-1:0]     den_next[DIV_STAGES];
    logic             neg_reg [DIV_STAGES];
    logic             neg_next[DIV_STAGES];
    logic [C-1:0]     mag;

    always_comb begin
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] trial;
        logic [QB-1:0]    qv;
        logic [C-1:0]     dv;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                r  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                qv = '0;
                dv = den;
                neg_next[s] = num[NUM_W-1];
            end else begin
                r  = rem_reg[s-1];
                qv = quo_reg[s-1];
                dv = den_reg[s-1];
                neg_next[s] = neg_reg[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                trial = NUM_W'(dv) << (QB - 1 - 2 * s - j);
                if (r >= trial) begin
                    r = r - trial;
                    qv[QB-1-2*s-j] = 1'b1;
                end
            end
            rem_next[s] = r;
            quo_next[s] = qv;
            den_next[s] = dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_next;
            neg_reg <= neg_next;
        end
    end

    assign mag = quo_reg[DIV_STAGES-1][C-1:0];
    assign quo = neg_reg[DIV_STAGES-1] ? C'(-mag) : mag;

endmodule

// ===== rtl/core/line_segment_window_clip.sv =====
// ============================================================================
// line_segment_window_clip: segment clipper against a rectangular window
// Liang-Barsky clipping with exact rational arithmetic, fully pipelined.
// ============================================================================
// Accepts one segment per clock and returns one result per segment, in order.
// Results pass through two setup stages, two selection stages, the
// interpolation dividers that resolve two quotient bits per stage, and the
// output register. Throughput is one item per cycle; backpressure on the
// result side stalls the whole pipeline.
// Window registers should be written only while the pipeline is empty.
module line_segment_window_clip import lswc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [C-1:0]       cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [TDATA_W-1:0] m_tdata,
    // visible
    output logic               m_tuser
);

    win_t   win_reg;
    logic   en;
    cand_t  cand;
    numer_t numer;
    logic   val_reg[DIV_STAGES];
    logic   vis_reg[DIV_STAGES];
    logic signed [C-1:0] qsx, qsy, qex, qey;
    logic   m_valid_reg, m_vis_reg;
    logic [IN_W-1:0] m_data_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.x_min <= WIN_MIN_RESET;
            win_reg.y_min <= WIN_MIN_RESET;
            win_reg.x_max <= WIN_MAX_RESET;
            win_reg.y_max <= WIN_MAX_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WIN_X_MIN: win_reg.x_min <= cfg_wdata;
                REG_WIN_Y_MIN: win_reg.y_min <= cfg_wdata;
                REG_WIN_X_MAX: win_reg.x_max <= cfg_wdata;
                REG_WIN_Y_MAX: win_reg.y_max <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lswc_setup u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .x1       (s_tdata[C-1:0]),
        .y1       (s_tdata[2*C-1:C]),
        .x2       (s_tdata[3*C-1:2*C]),
        .y2       (s_tdata[4*C-1:3*C]),
        .win      (win_reg),
        .cand     (cand)
    );

    lswc_select u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cand    (cand),
        .numer   (numer)
    );

    lswc_div u_div_sx (.aclk(aclk), .en(en), .num(numer.sx), .den(numer.d1), .quo(qsx));
    lswc_div u_div_sy (.aclk(aclk), .en(en), .num(numer.sy), .den(numer.d1), .quo(qsy));
    lswc_div u_div_ex (.aclk(aclk), .en(en), .num(numer.ex), .den(numer.d2), .quo(qex));
    lswc_div u_div_ey (.aclk(aclk), .en(en), .num(numer.ey), .den(numer.d2), .quo(qey));

    // valid / visible ride alongside the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                val_reg[s] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            val_reg[0] <= numer.valid;
            vis_reg[0] <= numer.visible;
            for (int s = 1; s < DIV_STAGES; s++) begin
                val_reg[s] <= val_reg[s-1];
                vis_reg[s] <= vis_reg[s-1];
            end
            m_valid_reg <= val_reg[DIV_STAGES-1];
            m_vis_reg   <= vis_reg[DIV_STAGES-1];
            m_data_reg  <= vis_reg[DIV_STAGES-1] ? {qey, qex, qsy, qsx} : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_vis_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Line segment window clip testbench
// Drives segments through the stream port, predicts each clipped result with
// exact rational Liang-Barsky arithmetic and checks results in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lswc_pkg::*;

    typedef struct {
        bit               visible;
        bit signed [11:0] sx, sy, ex, ey;
    } clip_t;

    class clip_scoreboard;
        longint xmin = 200, ymin = 200, xmax = 400, ymax = 400;
        clip_t  pending[$];
        int     mismatches = 0;

        function void set_window(logic [1:0] idx, logic signed [11:0] v);
            case (idx)
                REG_WIN_X_MIN: xmin = v;
                REG_WIN_Y_MIN: ymin = v;
                REG_WIN_X_MAX: xmax = v;
                REG_WIN_Y_MAX: ymax = v;
            endcase
        endfunction

        function longint lerp(longint s, longint d, longint n, longint den);
            return (s * den + d * n) / den;
        endfunction

        function void note_segment(logic signed [11:0] x1, y1, x2, y2);
            longint dx, dy, n1, d1, n2, d2, n, d;
            longint p[4], q[4];
            bit     rej;
            clip_t  r;
            dx = x2 - x1; dy = y2 - y1;
            n1 = 0; d1 = 1; n2 = 1; d2 = 1; rej = 0;
            p[0] = -dx; q[0] = x1 - xmin;
            p[1] = dx;  q[1] = xmax - x1;
            p[2] = -dy; q[2] = y1 - ymin;
            p[3] = dy;  q[3] = ymax - y1;
            for (int i = 0; i < 4; i++) begin
                if (p[i] == 0) begin
                    if (q[i] < 0) rej = 1;
                end else if (p[i] < 0) begin
                    n = -q[i]; d = -p[i];
                    if (n * d1 > n1 * d) begin n1 = n; d1 = d; end
                end else begin
                    n = q[i]; d = p[i];
                    if (n * d2 < n2 * d) begin n2 = n; d2 = d; end
                end
            end
            if (!rej && n1 * d2 > n2 * d1) rej = 1;
            r = '{0, 0, 0, 0, 0};
            if (!rej) begin
                r.visible = 1;
                r.sx = 12'(lerp(x1, dx, n1, d1));
                r.sy = 12'(lerp(y1, dy, n1, d1));
                r.ex = 12'(lerp(x1, dx, n2, d2));
                r.ey = 12'(lerp(y1, dy, n2, d2));
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic vis, logic [47:0] data);
            clip_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result vis=%0b data=%h", vis, data);
                return;
            end
            e = pending.pop_front();
            if (vis !== e.visible || data[11:0] !== e.sx || data[23:12] !== e.sy ||
                data[35:24] !== e.ex || data[47:36] !== e.ey) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp vis=%0b %0d,%0d %0d,%0d got vis=%0b %0d,%0d %0d,%0d",
                        e.visible, e.sx, e.sy, e.ex, e.ey, vis,
                        $signed(data[11:0]), $signed(data[23:12]),
                        $signed(data[35:24]), $signed(data[47:36]));
            end
        endfunction
    endclass

    logic               aclk = 0, aresetn = 0;
    logic               cfg_wr_en = 0;
    logic [1:0]         cfg_addr = '0;
    logic [C-1:0]       cfg_wdata = '0;
    logic               s_tvalid = 0, s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid, m_tready = 0, m_tuser;
    logic [TDATA_W-1:0] m_tdata;

    clip_scoreboard sb = new();
    int  send_idle = 15, recv_idle = 66;
    int  quiet_cycles = 0;
    bit  running = 0;

    line_segment_window_clip u_top (.*);

    initial forever #6 aclk = ~aclk;

    // receiver: sample at rise, change ready at fall
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[47:0]);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > 2000) begin
            $display("FAILURE");
            $finish;
        end
    end
    always @(negedge aclk) m_tready <= running && ($urandom_range(99) >= recv_idle);

    task automatic write_reg(logic [1:0] idx, logic signed [11:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        sb.set_window(idx, v);
    endtask

    task automatic set_window(logic signed [11:0] x0, y0, x1, y1);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (15) @(negedge aclk);
        write_reg(REG_WIN_X_MIN, x0); write_reg(REG_WIN_Y_MIN, y0);
        write_reg(REG_WIN_X_MAX, x1); write_reg(REG_WIN_Y_MAX, y1);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    // with tvalid still high, so requests can follow back to back
    task automatic send_segment(logic signed [11:0] x1, y1, x2, y2);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {x2, y2, x1, y1} == 0 ? '0 : TDATA_W'({y2, x2, y1, x1});
        do @(posedge aclk); while (!s_tready);
        sb.note_segment(x1, y1, x2, y2);
        @(negedge aclk);
    endtask

    function automatic logic signed [11:0] coord_near(logic signed [11:0] lo, hi);
        int r = $urandom_range(9);
        if (r < 2) return 12'($urandom);
        if (r == 2) return ($urandom_range(1) != 0) ? 12'sh7ff : 12'sh800;
        return 12'($signed(int'(lo)) - 40 + $urandom_range(int'(hi) - int'(lo) + 80));
    endfunction

    task automatic random_run(int count, logic signed [11:0] lo, hi);
        for (int i = 0; i < count; i++) begin
            logic signed [11:0] a, b;
            a = coord_near(lo, hi); b = coord_near(lo, hi);
            if ($urandom_range(9) == 0) send_segment(a, b, a, b);
            else if ($urandom_range(9) == 0) send_segment(a, b, a, coord_near(lo, hi));
            else send_segment(a, b, coord_near(lo, hi), coord_near(lo, hi));
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        running = 1;
        @(negedge aclk);
        // default window: inside, crossing, parallel, single points, extremes
        send_segment(250, 250, 350, 350);
        send_segment(100, 300, 500, 300);
        send_segment(300, 100, 300, 500);
        send_segment(100, 100, 150, 500);
        send_segment(100, 450, 500, 450);
        send_segment(300, 300, 300, 300);
        send_segment(400, 400, 400, 400);
        send_segment(401, 300, 401, 300);
        send_segment(-2048, -2048, 2047, 2047);
        send_segment(2047, -2048, -2048, 2047);
        send_segment(0, 400, 400, 800);
        send_segment(450, 300, 300, 450);
        send_segment(-2048, 300, 2047, 301);
        send_segment(350, 399, 500, 401);
        random_run(300, 200, 400);
        set_window(-2048, -2048, 2047, 2047);
        send_segment(-2048, -2048, 2047, 2047);
        send_segment(2047, 2047, -2048, -2048);
        random_run(250, -2048, 2047);
        set_window(-5, 10, 37, 11);
        random_run(250, -5, 37);
        send_idle = 66; recv_idle = 15;
        set_window(300, 300, 100, 100); // inverted
        send_segment(200, 200, 200, 200);
        random_run(150, 100, 300);
        set_window(2047, 2047, 2047, 2047);
        send_segment(2047, 2047, 2047, 2047);
        random_run(100, 2000, 2047);
        set_window(-2048, -100, 0, 900);
        random_run(350, -2048, 900);
        send_idle = 0; recv_idle = 0;
        set_window(200, 200, 400, 400);
        random_run(500, 150, 450);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (sb.mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
